/* src/lcu_pkg.sv */
package lcu_pkg;

  // Default world limits; the top level hands its parameters down from these.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field and register widths fixed by the interface.
  localparam int OP_W    = 1;
  localparam int COORD_W = 6;
  localparam int AGE_W   = 4;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Wide enough for a clamped world size of up to 256 and any 7-bit setting.
  localparam int DIM_W = 9;

  // Neighbor counts run 0..8.
  localparam int CNT_W = 4;

  // Read sequence: the cell itself first, then its eight neighbors.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_CENTER = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;

  localparam logic [OP_W-1:0] OP_WRITE   = 1'b0;
  localparam logic [OP_W-1:0] OP_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_COLS = 1'b1;

  localparam logic [CFG_W-1:0] WORLD_ROWS_RST = 7'd64;
  localparam logic [CFG_W-1:0] WORLD_COLS_RST = 7'd64;

  localparam logic [AGE_W-1:0] AGE_MAX     = 4'd9;
  localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_LOW = 4'd2;

  typedef struct packed {
    logic              load;
    logic              wr_en;
    logic              rd_en;
    logic [STEP_W-1:0] step;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_compute;
    logic out_free;
  } status_t;

endpackage

/* src/life_cell_update_torus_age.sv */
// Game of Life cell engine on a torus whose live cells carry an age (1..9, 0 is dead).
// The grid of MAX_ROWS by MAX_COLS ages sits in one single-port RAM; world_rows and
// world_cols (register indexes 0 and 1, clamped to 1..MAX) set the wrap lengths and
// may only be written while the block is idle. A write item (op 0) stores its age,
// saturated at 9, in a write state with no result. A compute item (op 1) reads the
// cell and its eight wrapped neighbors one per cycle through the single RAM port,
// then registers its result in a finish state that waits while the result register
// holds an untaken result; the input side stays stalled until that hand-off.
// An item whose row or column is outside the world is dropped in its accept cycle
// with no result. The result register frees the input side, so the next item is
// taken while a result still waits to be taken.
// Grid cells are not cleared by reset and every cell must be written before it is read.
module life_cell_update_torus_age import lcu_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [COORD_W-1:0]   in_row,
  input  logic [COORD_W-1:0]   in_col,
  input  logic [AGE_W-1:0]     in_cell_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AGE_W-1:0]     out_next_age
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences the accept, the grid write or the nine grid reads,
  // and the hand-off of the finished age into the result register.
  lcu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the wrap arithmetic, the grid RAM, the
  // neighbor counter, the life rule and the result register.
  lcu_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_op),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_next_age  (out_next_age),
    .cmd           (cmd),
    .status        (status)
  );

  // A result can never appear in the cycle right after an accept.
  a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result appeared right after an item was accepted");

  // A valid compute item keeps the input side stalled at the last step of its read sequence.
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && status.in_range && status.is_compute) |-> ##9 in_stall)
    else $error("input taken during a compute read sequence");

  // The grid port never writes and reads in the same cycle.
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_en))
    else $error("grid write and read issued together");

  // Every result is a legal age.
  a_age_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_age <= AGE_MAX))
    else $error("result age above the maximum");

endmodule

/* src/lcu_ram.sv */
module lcu_ram import lcu_pkg::*; #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port; read data is registered and holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/lcu_ctrl.sv */
module lcu_ctrl import lcu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WRITE  = 4'b0010,
    S_READ   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    cmd.step   = step_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          step_nxt = STEP_CENTER;
          if (!status.in_range) begin
            state_nxt = S_IDLE;
          end else if (status.is_compute) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_FINISH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_CENTER;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

/* src/lcu_dpath.sv */
module lcu_dpath import lcu_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [OP_W-1:0]      in_op,
  input  logic [COORD_W-1:0]   in_row,
  input  logic [COORD_W-1:0]   in_col,
  input  logic [AGE_W-1:0]     in_cell_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AGE_W-1:0]     out_next_age,
  input  cmd_t                 cmd,
  output status_t              status
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CFG_W-1:0] world_rows_r, world_cols_r;
  logic [DIM_W-1:0] rows, cols;
  logic [DIM_W-1:0] row9, col9, up9, dn9, lf9, rt9;

  logic [ROW_W-1:0] row_r, up_r, dn_r, row_sel;
  logic [COL_W-1:0] col_r, lf_r, rt_r, col_sel;
  logic [AGE_W-1:0] val_r, val_sat;
  logic [ADDR_W-1:0] addr;
  logic [AGE_W-1:0]  rdata;

  logic              rd_vld_r;
  logic [STEP_W-1:0] rd_step_r;
  logic [CNT_W-1:0]  count_r, count_all;
  logic [AGE_W-1:0]  center_r, age;
  logic              out_valid_r;
  logic [AGE_W-1:0]  out_age_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_rows_r <= WORLD_ROWS_RST;
      world_cols_r <= WORLD_COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WORLD_ROWS: world_rows_r <= cfg_wdata;
        CFG_WORLD_COLS: world_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // World size in use, clamped to [1, MAX].
  always_comb begin
    if (world_rows_r == '0) begin
      rows = DIM_W'(1);
    end else if (DIM_W'(world_rows_r) > DIM_W'(MAX_ROWS)) begin
      rows = DIM_W'(MAX_ROWS);
    end else begin
      rows = DIM_W'(world_rows_r);
    end
    if (world_cols_r == '0) begin
      cols = DIM_W'(1);
    end else if (DIM_W'(world_cols_r) > DIM_W'(MAX_COLS)) begin
      cols = DIM_W'(MAX_COLS);
    end else begin
      cols = DIM_W'(world_cols_r);
    end
  end

  // Wrapped neighbor coordinates of the incoming cell.
  always_comb begin
    row9 = DIM_W'(in_row);
    col9 = DIM_W'(in_col);
    up9  = (row9 == '0) ? rows - 1'b1 : row9 - 1'b1;
    dn9  = (row9 + 1'b1 >= rows) ? '0 : row9 + 1'b1;
    lf9  = (col9 == '0) ? cols - 1'b1 : col9 - 1'b1;
    rt9  = (col9 + 1'b1 >= cols) ? '0 : col9 + 1'b1;
  end

  assign val_sat = (in_cell_value > AGE_MAX) ? AGE_MAX : in_cell_value;

  assign status.in_range   = (row9 < rows) && (col9 < cols);
  assign status.is_compute = (in_op == OP_COMPUTE);
  assign status.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= row9[ROW_W-1:0];
      up_r  <= up9[ROW_W-1:0];
      dn_r  <= dn9[ROW_W-1:0];
      col_r <= col9[COL_W-1:0];
      lf_r  <= lf9[COL_W-1:0];
      rt_r  <= rt9[COL_W-1:0];
      val_r <= val_sat;
    end
  end

  // Cell at each read step: the cell itself, then the neighbors row by row.
  always_comb begin
    case (cmd.step)
      4'd1, 4'd2, 4'd3: row_sel = up_r;
      4'd6, 4'd7, 4'd8: row_sel = dn_r;
      default:          row_sel = row_r;
    endcase
    case (cmd.step)
      4'd1, 4'd4, 4'd6: col_sel = lf_r;
      4'd3, 4'd5, 4'd8: col_sel = rt_r;
      default:          col_sel = col_r;
    endcase
  end

  assign addr = ADDR_W'(row_sel) * ADDR_W'(MAX_COLS) + ADDR_W'(col_sel);

  lcu_ram #(
    .WIDTH (AGE_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (cmd.wr_en),
    .re    (cmd.rd_en),
    .addr  (addr),
    .wdata (val_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_step_r <= cmd.step;
  end

  // The last neighbor is added on the fly when the result is formed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r <= '0;
    end else if (rd_vld_r) begin
      if (rd_step_r == STEP_CENTER) begin
        center_r <= rdata;
      end else if (rd_step_r != STEP_LAST) begin
        count_r <= count_r + CNT_W'(rdata != '0);
      end
    end
  end

  assign count_all = count_r + CNT_W'(rdata != '0);

  always_comb begin
    if (center_r == '0) begin
      age = (count_all == BIRTH_COUNT) ? AGE_W'(1) : '0;
    end else if (count_all == SURVIVE_LOW || count_all == BIRTH_COUNT) begin
      age = (center_r < AGE_MAX) ? center_r + 1'b1 : AGE_MAX;
    end else begin
      age = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_age_r <= age;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_next_age = out_age_r;

endmodule
